// ===== hw/rtl/lru_keyed_handle_cache_assert.svh =====
// Assertion macros shared by the cache RTL.
`ifndef LRU_KEYED_HANDLE_CACHE_ASSERT_SVH
`define LRU_KEYED_HANDLE_CACHE_ASSERT_SVH

// Check that cons holds in the same cycle as ante.
`define LKHC_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Check that cons holds in the cycle after ante.
`define LKHC_ASSERT_NXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Check that cond holds in every cycle out of reset.
`define LKHC_ASSERT_ALW(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error(msg);

`endif

// ===== hw/rtl/lkhc_pkg.sv =====
// Types, codes and layout helpers for the keyed handle cache.
package lkhc_pkg;

    localparam int ENTRIES_DEF  = 16;
    localparam int MAX_RANK_DEF = 4;

    localparam int IN_DIMS  = 4;
    localparam int DIM_W    = 31;
    localparam int RANK_W   = 3;
    localparam int HANDLE_W = 16;
    localparam int CAP_W    = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

    // Request codes
    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_LOOKUP = 2'd1;
    localparam logic [1:0] OP_PEEK   = 2'd2;
    localparam logic [1:0] OP_PROBE  = 2'd3;

    // Entry unit update modes
    typedef logic [1:0] t_mode;
    localparam t_mode MODE_KEEP  = 2'd0;
    localparam t_mode MODE_TOUCH = 2'd1;
    localparam t_mode MODE_AGE   = 2'd2;

    typedef struct packed {
        t_mode mode;
        logic  do_evict;
        logic  is_target;
    } t_unit_ctl;

    // Dimensions actually stored per entry
    function automatic int key_dims(int max_rank);
        return (max_rank < IN_DIMS) ? max_rank : IN_DIMS;
    endfunction

    // Entry word: valid, rank, dims, exec, func, recency (MSB to LSB)
    function automatic int entry_width(int dims, int rec_w);
        return 1 + RANK_W + dims * DIM_W + 2 * HANDLE_W + rec_w;
    endfunction

endpackage

// ===== hw/rtl/lru_keyed_handle_cache.sv =====
// Top level of the keyed handle cache: request sequencer, entry RAM and entry unit.
//
// Fully associative LRU cache keyed by a tensor shape. Requests are taken on
// start while busy is low; each gives one result on o_hit, o_status and the
// handle outputs, shown for exactly one cycle with o_done, in the same cycle
// that busy falls. The receiver cannot stall, so capture it then. The entries
// live in one RAM that a sequencer sweeps with one shared compare and update
// unit, one entry per cycle. A search pass reads each entry, waits on the
// registered read and then decides, so peek, probe and any miss other than an
// insert end after the search pass. A lookup hit or an insert of a present key
// adds a recency pass, and an insert of a new key adds a recency pass that
// ages the entries and then one more write of the new entry. After reset the
// block clears every RAM entry with busy high. Capacity writes are accepted
// only while busy is low and take effect on the next request.
`include "lru_keyed_handle_cache_assert.svh"

module lru_keyed_handle_cache
    import lkhc_pkg::*;
#(
    parameter int ENTRIES  = ENTRIES_DEF,
    parameter int MAX_RANK = MAX_RANK_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [1:0]          i_operation,
    input  logic [RANK_W-1:0]   i_shape_rank,
    input  logic [DIM_W-1:0]    i_dim_a,
    input  logic [DIM_W-1:0]    i_dim_b,
    input  logic [DIM_W-1:0]    i_dim_c,
    input  logic [DIM_W-1:0]    i_dim_d,
    input  logic [HANDLE_W-1:0] i_exec_handle_in,
    input  logic [HANDLE_W-1:0] i_func_handle_in,
    output logic                o_done,
    output logic                o_hit,
    output logic                o_status,
    output logic [HANDLE_W-1:0] o_exec_handle_out,
    output logic [HANDLE_W-1:0] o_func_handle_out,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [CAP_W-1:0]    i_cfg_data
);

    localparam int D    = key_dims(MAX_RANK);
    localparam int RW   = $clog2(ENTRIES);
    localparam int CW   = $clog2(ENTRIES + 1);
    localparam int CAPW = (CW > CAP_W) ? CW : CAP_W;
    localparam int WW   = entry_width(D, RW);

    localparam logic [2:0] S_CLEAR  = 3'd0;
    localparam logic [2:0] S_IDLE   = 3'd1;
    localparam logic [2:0] S_SEARCH = 3'd2;
    localparam logic [2:0] S_UPDATE = 3'd3;
    localparam logic [2:0] S_INSERT = 3'd4;

    // Control registers
    logic [2:0]          r_state, n_state;
    logic [CW-1:0]       r_idx, n_idx;
    logic                r_pval, n_pval;
    logic                r_found, n_found;
    logic                r_slot_found, n_slot_found;
    logic [CW-1:0]       r_count, n_count;
    logic [CAP_W-1:0]    r_cap, n_cap;
    logic                r_done, n_done;
    t_mode               r_mode, n_mode;

    // Payload registers
    logic [RW-1:0]           r_pidx, n_pidx;
    logic [1:0]              r_op, n_op;
    logic [RANK_W-1:0]       r_rank, n_rank;
    logic [D-1:0][DIM_W-1:0] r_dims, n_dims;
    logic [HANDLE_W-1:0]     r_xin, n_xin;
    logic [HANDLE_W-1:0]     r_fin, n_fin;
    logic [RW-1:0]           r_eidx, n_eidx;
    logic [RW-1:0]           r_erec, n_erec;
    logic [HANDLE_W-1:0]     r_ex, n_ex;
    logic [HANDLE_W-1:0]     r_fx, n_fx;
    logic [RW-1:0]           r_slot, n_slot;
    logic                    r_hit, n_hit;
    logic                    r_status, n_status;
    logic [HANDLE_W-1:0]     r_xout, n_xout;
    logic [HANDLE_W-1:0]     r_fout, n_fout;

    logic [IN_DIMS-1:0][DIM_W-1:0] w_in_dims;
    logic [CAPW-1:0]     w_cap_raw;
    logic [CW-1:0]       w_cap_eff;
    logic [RW-1:0]       w_thr;
    logic                w_do_evict;
    logic                w_pass_done;
    logic                w_finish;
    logic                w_reads_handles;

    logic                w_we;
    logic [RW-1:0]       w_waddr;
    logic [WW-1:0]       w_wdata;
    logic                w_re;
    logic [RW-1:0]       w_raddr;
    logic [WW-1:0]       w_rdata;

    t_unit_ctl           w_ctl;
    logic                u_match;
    logic                u_valid_upd;
    logic [RW-1:0]       u_rec;
    logic [HANDLE_W-1:0] u_exec;
    logic [HANDLE_W-1:0] u_func;
    logic [WW-1:0]       u_upd_word;
    logic [WW-1:0]       u_new_word;

    assign w_in_dims = {i_dim_d, i_dim_c, i_dim_b, i_dim_a};

    // Clamp capacity to 1..ENTRIES and derive the eviction threshold
    always_comb begin
        w_cap_raw = CAPW'(r_cap);
        if (w_cap_raw == '0) begin
            w_cap_eff = CW'(1);
        end else if (w_cap_raw > CAPW'(ENTRIES)) begin
            w_cap_eff = CW'(ENTRIES);
        end else begin
            w_cap_eff = CW'(w_cap_raw);
        end
        w_thr      = RW'(w_cap_eff - CW'(1));
        w_do_evict = (r_count >= w_cap_eff);
    end

    assign w_ctl = '{mode: r_mode, do_evict: w_do_evict, is_target: (r_pidx == r_eidx)};

    lkhc_ram #(
        .WIDTH (WW),
        .DEPTH (ENTRIES)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    lkhc_entry_unit #(
        .ENTRIES  (ENTRIES),
        .MAX_RANK (MAX_RANK)
    ) u_unit (
        .i_word      (w_rdata),
        .i_ctl       (w_ctl),
        .i_ref_rec   (r_erec),
        .i_thr       (w_thr),
        .i_rank      (r_rank),
        .i_dims      (r_dims),
        .i_xin       (r_xin),
        .i_fin       (r_fin),
        .o_match     (u_match),
        .o_valid_upd (u_valid_upd),
        .o_rec       (u_rec),
        .o_exec      (u_exec),
        .o_func      (u_func),
        .o_upd_word  (u_upd_word),
        .o_new_word  (u_new_word)
    );

    assign w_pass_done     = (r_idx == CW'(ENTRIES)) && !r_pval;
    assign w_reads_handles = (r_op == OP_LOOKUP) || (r_op == OP_PEEK);

    // Sequencer: clear, search pass, recency pass, insert write
    always_comb begin
        n_state      = r_state;
        n_idx        = r_idx;
        n_pval       = r_pval;
        n_found      = r_found;
        n_slot_found = r_slot_found;
        n_count      = r_count;
        n_cap        = r_cap;
        n_done       = 1'b0;
        n_mode       = r_mode;
        n_pidx       = r_pidx;
        n_op         = r_op;
        n_rank       = r_rank;
        n_dims       = r_dims;
        n_xin        = r_xin;
        n_fin        = r_fin;
        n_eidx       = r_eidx;
        n_erec       = r_erec;
        n_ex         = r_ex;
        n_fx         = r_fx;
        n_slot       = r_slot;
        n_hit        = r_hit;
        n_status     = r_status;
        n_xout       = r_xout;
        n_fout       = r_fout;
        w_finish     = 1'b0;

        w_re    = ((r_state == S_SEARCH) || (r_state == S_UPDATE)) && (r_idx != CW'(ENTRIES));
        w_raddr = r_idx[RW-1:0];
        w_we    = 1'b0;
        w_waddr = r_pidx;
        w_wdata = u_upd_word;

        // Advance the sweep one entry per cycle
        if ((r_state == S_SEARCH) || (r_state == S_UPDATE)) begin
            n_idx  = r_idx + CW'(w_re);
            n_pval = w_re;
            n_pidx = w_raddr;
        end

        // Take capacity writes while idle
        if (i_cfg_valid && o_cfg_ready) begin
            n_cap = i_cfg_data;
        end

        unique case (r_state)
            S_CLEAR: begin
                w_we    = 1'b1;
                w_waddr = r_idx[RW-1:0];
                w_wdata = '0;
                n_idx   = r_idx + CW'(1);
                if (r_idx[RW-1:0] == RW'(ENTRIES - 1)) begin
                    n_state = S_IDLE;
                    n_idx   = '0;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_SEARCH;
                    n_idx   = '0;
                    n_pval  = 1'b0;
                    n_found = 1'b0;
                    n_op    = i_operation;
                    n_rank  = i_shape_rank;
                    n_xin   = i_exec_handle_in;
                    n_fin   = i_func_handle_in;
                    for (int i = 0; i < D; i++) begin
                        n_dims[i] = w_in_dims[i];
                    end
                end
            end
            S_SEARCH: begin
                // Keep the first matching entry
                if (r_pval && u_match && !r_found) begin
                    n_found = 1'b1;
                    n_eidx  = r_pidx;
                    n_erec  = u_rec;
                    n_ex    = u_exec;
                    n_fx    = u_func;
                end
                if (w_pass_done) begin
                    n_idx        = '0;
                    n_slot_found = 1'b0;
                    if (r_found && ((r_op == OP_INSERT) || (r_op == OP_LOOKUP))) begin
                        n_mode  = MODE_TOUCH;
                        n_state = S_UPDATE;
                    end else if (!r_found && (r_op == OP_INSERT)) begin
                        n_mode  = MODE_AGE;
                        n_state = S_UPDATE;
                    end else begin
                        w_finish = 1'b1;
                    end
                end
            end
            S_UPDATE: begin
                // Write back each entry; note the first free slot on insert
                if (r_pval) begin
                    w_we = 1'b1;
                    if ((r_mode == MODE_AGE) && !r_slot_found && !u_valid_upd) begin
                        n_slot_found = 1'b1;
                        n_slot       = r_pidx;
                    end
                end
                if (w_pass_done) begin
                    if (r_mode == MODE_AGE) begin
                        n_state = S_INSERT;
                    end else begin
                        w_finish = 1'b1;
                    end
                end
            end
            S_INSERT: begin
                w_we    = 1'b1;
                w_waddr = r_slot;
                w_wdata = u_new_word;
                n_count = w_do_evict ? w_cap_eff : (r_count + CW'(1));
                w_finish = 1'b1;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Drive the result with a one-cycle done strobe and drop back to idle
        if (w_finish) begin
            n_state  = S_IDLE;
            n_mode   = MODE_KEEP;
            n_done   = 1'b1;
            n_hit    = r_found;
            n_status = !r_found && w_reads_handles;
            n_xout   = (r_found && w_reads_handles) ? r_ex : '0;
            n_fout   = (r_found && w_reads_handles) ? r_fx : '0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_CLEAR;
            r_idx        <= '0;
            r_pval       <= 1'b0;
            r_found      <= 1'b0;
            r_slot_found <= 1'b0;
            r_count      <= '0;
            r_cap        <= CAP_RESET;
            r_done       <= 1'b0;
            r_mode       <= MODE_KEEP;
        end else begin
            r_state      <= n_state;
            r_idx        <= n_idx;
            r_pval       <= n_pval;
            r_found      <= n_found;
            r_slot_found <= n_slot_found;
            r_count      <= n_count;
            r_cap        <= n_cap;
            r_done       <= n_done;
            r_mode       <= n_mode;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        r_pidx   <= n_pidx;
        r_op     <= n_op;
        r_rank   <= n_rank;
        r_dims   <= n_dims;
        r_xin    <= n_xin;
        r_fin    <= n_fin;
        r_eidx   <= n_eidx;
        r_erec   <= n_erec;
        r_ex     <= n_ex;
        r_fx     <= n_fx;
        r_slot   <= n_slot;
        r_hit    <= n_hit;
        r_status <= n_status;
        r_xout   <= n_xout;
        r_fout   <= n_fout;
    end

    assign busy              = (r_state != S_IDLE);
    assign o_cfg_ready       = !busy;
    assign o_done            = r_done;
    assign o_hit             = r_hit;
    assign o_status          = r_status;
    assign o_exec_handle_out = r_xout;
    assign o_func_handle_out = r_fout;

    `LKHC_ASSERT_IMP(a_done_ends_busy, i_clk, i_rst_n, o_done, $past(busy), "result without work")
    `LKHC_ASSERT_NXT(a_start_sets_busy, i_clk, i_rst_n, start && !busy, busy, "item not taken")
    `LKHC_ASSERT_ALW(a_count_bound, i_clk, i_rst_n, r_count <= CW'(ENTRIES), "count overflow")
    `LKHC_ASSERT_IMP(a_miss_clean, i_clk, i_rst_n, o_done && o_status, !o_hit && (o_exec_handle_out == '0) && (o_func_handle_out == '0), "bad miss result")
    `LKHC_ASSERT_IMP(a_port_clash, i_clk, i_rst_n, w_we && w_re, w_waddr != w_raddr, "RAM address clash")

endmodule

// ===== hw/rtl/lkhc_ram.sv =====
// Generic simple dual-port RAM with registered read.
module lkhc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== hw/rtl/lkhc_entry_unit.sv =====
// Shared entry unit: key compare, recency update and entry packing.
module lkhc_entry_unit
    import lkhc_pkg::*;
#(
    parameter int ENTRIES  = ENTRIES_DEF,
    parameter int MAX_RANK = MAX_RANK_DEF,
    localparam int D  = key_dims(MAX_RANK),
    localparam int RW = $clog2(ENTRIES),
    localparam int WW = entry_width(D, RW)
) (
    input  logic [WW-1:0]             i_word,
    input  t_unit_ctl                 i_ctl,
    input  logic [RW-1:0]             i_ref_rec,
    input  logic [RW-1:0]             i_thr,
    input  logic [RANK_W-1:0]         i_rank,
    input  logic [D-1:0][DIM_W-1:0]   i_dims,
    input  logic [HANDLE_W-1:0]       i_xin,
    input  logic [HANDLE_W-1:0]       i_fin,
    output logic                      o_match,
    output logic                      o_valid_upd,
    output logic [RW-1:0]             o_rec,
    output logic [HANDLE_W-1:0]       o_exec,
    output logic [HANDLE_W-1:0]       o_func,
    output logic [WW-1:0]             o_upd_word,
    output logic [WW-1:0]             o_new_word
);

    localparam int FUNC_LSB  = RW;
    localparam int EXEC_LSB  = FUNC_LSB + HANDLE_W;
    localparam int DIMS_LSB  = EXEC_LSB + HANDLE_W;
    localparam int RANK_LSB  = DIMS_LSB + D * DIM_W;
    localparam int VALID_BIT = RANK_LSB + RANK_W;

    logic                    w_valid;
    logic [RANK_W-1:0]       w_rank;
    logic [D-1:0][DIM_W-1:0] w_dims;
    logic [RW-1:0]           w_rec;
    logic [D-1:0]            w_dim_ok;
    logic [D-1:0][DIM_W-1:0] w_new_dims;
    logic                    w_new_valid;
    logic [RW-1:0]           w_new_rec;

    // Unpack the stored entry
    always_comb begin
        w_valid = i_word[VALID_BIT];
        w_rank  = i_word[RANK_LSB +: RANK_W];
        w_dims  = i_word[DIMS_LSB +: D * DIM_W];
        w_rec   = i_word[RW-1:0];
        o_exec  = i_word[EXEC_LSB +: HANDLE_W];
        o_func  = i_word[FUNC_LSB +: HANDLE_W];
        o_rec   = w_rec;
    end

    // Compare only the dimensions below the key rank; clear the rest on store
    always_comb begin
        for (int i = 0; i < D; i++) begin
            w_dim_ok[i]   = (i_rank <= RANK_W'(i)) || (w_dims[i] == i_dims[i]);
            w_new_dims[i] = (i_rank > RANK_W'(i)) ? i_dims[i] : '0;
        end
        o_match = w_valid && (w_rank == i_rank) && (&w_dim_ok);
    end

    // Age, touch or evict the entry
    always_comb begin
        w_new_valid = w_valid;
        w_new_rec   = w_rec;
        unique case (i_ctl.mode)
            MODE_TOUCH: begin
                if (i_ctl.is_target) begin
                    w_new_rec = '0;
                end else if (w_valid && (w_rec < i_ref_rec)) begin
                    w_new_rec = w_rec + RW'(1);
                end
            end
            MODE_AGE: begin
                if (w_valid) begin
                    if (i_ctl.do_evict && (w_rec >= i_thr)) begin
                        w_new_valid = 1'b0;
                    end else begin
                        w_new_rec = w_rec + RW'(1);
                    end
                end
            end
            default: begin
                w_new_valid = w_valid;
            end
        endcase
        o_valid_upd = w_new_valid;
        o_upd_word  = {w_new_valid, i_word[VALID_BIT-1:RW], w_new_rec};
    end

    // Pack a fresh most-recent entry
    assign o_new_word = {1'b1, i_rank, w_new_dims, i_xin, i_fin, {RW{1'b0}}};

endmodule

// ===== dv/lru_keyed_handle_cache_tb.sv =====
// Testbench for the keyed handle cache: directed and random requests checked against a predictor.
`timescale 1ns / 100ps

module lru_keyed_handle_cache_tb;
    import lkhc_pkg::*;

    localparam int N_ENTRIES    = ENTRIES_DEF;
    localparam int N_MAX_RANK   = MAX_RANK_DEF;
    localparam int POOL_SIZE    = 20;
    localparam int PHASE_ITEMS  = 250;
    localparam int N_PHASES     = 8;
    localparam int SETTLE_CYC   = 2 * N_ENTRIES + 8;
    localparam logic [DIM_W-1:0] DMAX = {DIM_W{1'b1}};

    typedef struct packed {
        logic [1:0]                      op;
        logic [RANK_W-1:0]               rank;
        logic [IN_DIMS-1:0][DIM_W-1:0]   dims;
        logic [HANDLE_W-1:0]             exec_h;
        logic [HANDLE_W-1:0]             func_h;
    } cache_req_t;

    typedef struct packed {
        logic                hit;
        logic                status;
        logic [HANDLE_W-1:0] exec_h;
        logic [HANDLE_W-1:0] func_h;
    } cache_reply_t;

    typedef struct packed {
        cache_req_t   req;
        logic         typed;
        cache_reply_t reply;
    } stim_row_t;

    localparam cache_reply_t MISS_NOT_FOUND = {1'b0, 1'b1, 16'h0, 16'h0};
    localparam cache_reply_t MISS_OK        = {1'b0, 1'b0, 16'h0, 16'h0};
    localparam cache_reply_t HIT_NO_HANDLES = {1'b1, 1'b0, 16'h0, 16'h0};
    localparam cache_reply_t UNTYPED        = '0;

    // DUT ports
    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                start = 1'b0;
    logic                busy;
    logic [1:0]          i_operation = OP_INSERT;
    logic [RANK_W-1:0]   i_shape_rank = '0;
    logic [DIM_W-1:0]    i_dim_a = '0;
    logic [DIM_W-1:0]    i_dim_b = '0;
    logic [DIM_W-1:0]    i_dim_c = '0;
    logic [DIM_W-1:0]    i_dim_d = '0;
    logic [HANDLE_W-1:0] i_exec_handle_in = '0;
    logic [HANDLE_W-1:0] i_func_handle_in = '0;
    logic                o_done;
    logic                o_hit;
    logic                o_status;
    logic [HANDLE_W-1:0] o_exec_handle_out;
    logic [HANDLE_W-1:0] o_func_handle_out;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [CAP_W-1:0]    i_cfg_data = '0;

    // Predictor state
    logic                          slot_valid [N_ENTRIES];
    logic [RANK_W-1:0]             slot_rank  [N_ENTRIES];
    logic [IN_DIMS-1:0][DIM_W-1:0] slot_dims  [N_ENTRIES];
    logic [HANDLE_W-1:0]           slot_exec  [N_ENTRIES];
    logic [HANDLE_W-1:0]           slot_func  [N_ENTRIES];
    int                            slot_age   [N_ENTRIES];
    int                            live_count;
    logic [CAP_W-1:0]              capacity_setting;

    cache_reply_t awaited_replies [$];
    stim_row_t    directed_rows [$];
    cache_req_t   key_pool [POOL_SIZE];

    int mismatch_count = 0;
    int items_sent     = 0;
    int reply_count    = 0;
    int hit_count      = 0;
    int cap_writes     = 0;

    lru_keyed_handle_cache dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .start             (start),
        .busy              (busy),
        .i_operation       (i_operation),
        .i_shape_rank      (i_shape_rank),
        .i_dim_a           (i_dim_a),
        .i_dim_b           (i_dim_b),
        .i_dim_c           (i_dim_c),
        .i_dim_d           (i_dim_d),
        .i_exec_handle_in  (i_exec_handle_in),
        .i_func_handle_in  (i_func_handle_in),
        .o_done            (o_done),
        .o_hit             (o_hit),
        .o_status          (o_status),
        .o_exec_handle_out (o_exec_handle_out),
        .o_func_handle_out (o_func_handle_out),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_data        (i_cfg_data)
    );

    always #4 i_clk = ~i_clk;

    // Bound the run
    initial begin
        #8_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Number of dimensions that take part in a key compare
    function automatic int dims_used(logic [RANK_W-1:0] rank);
        int n;
        n = rank;
        if (n > N_MAX_RANK) n = N_MAX_RANK;
        if (n > IN_DIMS) n = IN_DIMS;
        return n;
    endfunction

    function automatic int find_slot(cache_req_t req);
        int  n;
        bit  same;
        n = dims_used(req.rank);
        for (int e = 0; e < N_ENTRIES; e++) begin
            if (slot_valid[e] && slot_rank[e] == req.rank) begin
                same = 1'b1;
                for (int i = 0; i < n; i++)
                    if (slot_dims[e][i] != req.dims[i]) same = 1'b0;
                if (same) return e;
            end
        end
        return -1;
    endfunction

    // Make an entry most recent, aging those that were more recent
    function automatic void promote(int e);
        int r;
        r = slot_age[e];
        for (int k = 0; k < N_ENTRIES; k++)
            if (slot_valid[k] && slot_age[k] < r) slot_age[k]++;
        slot_age[e] = 0;
    endfunction

    function automatic void evict_oldest();
        int victim;
        victim = -1;
        for (int e = 0; e < N_ENTRIES; e++)
            if (slot_valid[e] && (victim < 0 || slot_age[e] > slot_age[victim])) victim = e;
        if (victim >= 0) begin
            slot_valid[victim] = 1'b0;
            live_count--;
        end
    endfunction

    // Advance the cache contents by one request and return its reply
    function automatic cache_reply_t predict_reply(cache_req_t req);
        cache_reply_t rep;
        int cap;
        int e;
        int slot;
        int n;
        rep = '0;
        cap = capacity_setting;
        if (cap < 1) cap = 1;
        if (cap > N_ENTRIES) cap = N_ENTRIES;
        e = find_slot(req);
        rep.hit = (e >= 0);
        case (req.op)
            OP_INSERT: begin
                if (e >= 0) begin
                    promote(e);
                end else begin
                    while (live_count >= cap) evict_oldest();
                    slot = -1;
                    for (int k = 0; k < N_ENTRIES; k++)
                        if (!slot_valid[k] && slot < 0) slot = k;
                    if (slot >= 0) begin
                        n = dims_used(req.rank);
                        for (int k = 0; k < N_ENTRIES; k++)
                            if (slot_valid[k]) slot_age[k]++;
                        slot_valid[slot] = 1'b1;
                        slot_rank[slot]  = req.rank;
                        for (int i = 0; i < IN_DIMS; i++)
                            slot_dims[slot][i] = (i < n) ? req.dims[i] : '0;
                        slot_exec[slot] = req.exec_h;
                        slot_func[slot] = req.func_h;
                        slot_age[slot]  = 0;
                        live_count++;
                    end
                end
            end
            OP_LOOKUP, OP_PEEK: begin
                if (e >= 0) begin
                    rep.exec_h = slot_exec[e];
                    rep.func_h = slot_func[e];
                    if (req.op == OP_LOOKUP) promote(e);
                end else begin
                    rep.status = 1'b1;
                end
            end
            default: ;
        endcase
        return rep;
    endfunction

    function automatic void add_row(logic [1:0] op, logic [RANK_W-1:0] rank,
                                    logic [DIM_W-1:0] a, logic [DIM_W-1:0] b,
                                    logic [DIM_W-1:0] c, logic [DIM_W-1:0] d,
                                    logic [HANDLE_W-1:0] x, logic [HANDLE_W-1:0] f,
                                    bit typed, cache_reply_t want);
        stim_row_t row;
        row.req.op     = op;
        row.req.rank   = rank;
        row.req.dims   = {d, c, b, a};
        row.req.exec_h = x;
        row.req.func_h = f;
        row.typed      = typed;
        row.reply      = want;
        directed_rows.push_back(row);
    endfunction

    function automatic logic [DIM_W-1:0] random_dim();
        case ($urandom_range(0, 3))
            0:       return DIM_W'($urandom_range(0, 3));
            1:       return DMAX;
            default: return DIM_W'($urandom());
        endcase
    endfunction

    function automatic logic [HANDLE_W-1:0] random_handle();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            default: return HANDLE_W'($urandom_range(0, 65535));
        endcase
    endfunction

    // Mostly keys from the pool, with some fresh keys and near misses
    function automatic cache_req_t random_request();
        cache_req_t req;
        int pick;
        int sel;
        int pos;
        int n;
        pick = $urandom_range(0, 99);
        sel  = $urandom_range(0, 99);
        req.op = (sel < 35) ? OP_INSERT : (sel < 65) ? OP_LOOKUP :
                 (sel < 80) ? OP_PEEK : OP_PROBE;
        req.exec_h = random_handle();
        req.func_h = random_handle();
        if (pick < 12) begin
            req.rank = RANK_W'($urandom_range(0, 7));
            for (int i = 0; i < IN_DIMS; i++) req.dims[i] = DIM_W'($urandom());
        end else begin
            req.rank = key_pool[$urandom_range(0, POOL_SIZE - 1)].rank;
            req.dims = key_pool[$urandom_range(0, POOL_SIZE - 1)].dims;
            pos = $urandom_range(0, POOL_SIZE - 1);
            req.rank = key_pool[pos].rank;
            req.dims = key_pool[pos].dims;
            n = dims_used(req.rank);
            // scramble the dimensions the key ignores
            for (int i = n; i < IN_DIMS; i++)
                if ($urandom_range(0, 1)) req.dims[i] = DIM_W'($urandom());
            // flip one compared bit for a near miss
            if (pick < 18 && n > 0) begin
                pos = $urandom_range(0, n - 1);
                req.dims[pos] = req.dims[pos] ^ (DIM_W'(1) << $urandom_range(0, DIM_W - 1));
            end
        end
        return req;
    endfunction

    function automatic int sender_gap(int idle_pct);
        if ($urandom_range(0, 99) >= idle_pct) return 0;
        if ($urandom_range(0, 3) == 0) return $urandom_range(1, 40);
        return $urandom_range(1, 3);
    endfunction

    // Present one item, hold it until accepted, and queue its reply
    task automatic issue_request(cache_req_t req, int gap, bit typed, cache_reply_t want);
        cache_reply_t predicted;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start            <= 1'b1;
        i_operation      <= req.op;
        i_shape_rank     <= req.rank;
        i_dim_a          <= req.dims[0];
        i_dim_b          <= req.dims[1];
        i_dim_c          <= req.dims[2];
        i_dim_d          <= req.dims[3];
        i_exec_handle_in <= req.exec_h;
        i_func_handle_in <= req.func_h;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predicted = predict_reply(req);
        awaited_replies.push_back(typed ? want : predicted);
        items_sent++;
    endtask

    // Drop start and wait for every outstanding reply
    task automatic hold_until_drained();
        start <= 1'b0;
        while (awaited_replies.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_capacity(logic [CAP_W-1:0] value);
        hold_until_drained();
        while (busy) @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= value;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        capacity_setting = value;
        cap_writes++;
    endtask

    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    // Compare each reply with the oldest outstanding one
    always @(posedge i_clk) begin
        cache_reply_t want;
        if (i_rst_n && o_done) begin
            reply_count++;
            if (o_hit) hit_count++;
            if (awaited_replies.size() == 0) begin
                $error("reply with none outstanding: hit %0b status %0b", o_hit, o_status);
                mismatch_count++;
            end else begin
                want = awaited_replies.pop_front();
                check_field("hit", want.hit, o_hit);
                check_field("status", want.status, o_status);
                check_field("exec_handle_out", want.exec_h, o_exec_handle_out);
                check_field("func_handle_out", want.func_h, o_func_handle_out);
            end
        end
    end

    // Main stimulus
    initial begin
        int idle_plan [N_PHASES];
        int cap_plan  [N_PHASES];
        stim_row_t row;
        idle_plan = '{0, 57, 57, 32, 0, 57, 32, 57};
        cap_plan  = '{1, 0, 31, 4, 17, 2, 16, 9};
        cap_plan[N_PHASES - 1] = $urandom_range(3, 15);

        for (int e = 0; e < N_ENTRIES; e++) begin
            slot_valid[e] = 1'b0;
            slot_age[e]   = 0;
        end
        live_count       = 0;
        capacity_setting = CAP_RESET;

        for (int k = 0; k < POOL_SIZE; k++) begin
            key_pool[k].rank = RANK_W'($urandom_range(0, 7));
            for (int i = 0; i < IN_DIMS; i++) key_pool[k].dims[i] = random_dim();
        end

        // Misses on an empty cache, extremes, rank edge cases, refresh of a present key
        add_row(OP_LOOKUP, 2, 5, 7, 0, 0, 0, 0, 1, MISS_NOT_FOUND);
        add_row(OP_PEEK,   2, 5, 7, 0, 0, 0, 0, 1, MISS_NOT_FOUND);
        add_row(OP_PROBE,  2, 5, 7, 0, 0, 0, 0, 1, MISS_OK);
        add_row(OP_INSERT, 4, DMAX, DMAX, DMAX, DMAX, 16'hFFFF, 16'hFFFF, 1, MISS_OK);
        add_row(OP_LOOKUP, 4, DMAX, DMAX, DMAX, DMAX, 0, 0, 1,
                {1'b1, 1'b0, 16'hFFFF, 16'hFFFF});
        add_row(OP_INSERT, 0, 1, 2, 3, 4, 16'h0000, 16'h0000, 1, MISS_OK);
        add_row(OP_INSERT, 0, DMAX, DMAX, DMAX, DMAX, 16'h1234, 16'hABCD, 1, HIT_NO_HANDLES);
        add_row(OP_PEEK,   0, 0, 0, 0, 0, 0, 0, 1, HIT_NO_HANDLES);
        add_row(OP_INSERT, 5, DMAX, DMAX, DMAX, DMAX, 16'h00FF, 16'hFF00, 1, MISS_OK);
        add_row(OP_PROBE,  5, DMAX, DMAX, DMAX, DMAX, 0, 0, 1, HIT_NO_HANDLES);
        add_row(OP_PEEK,   5, DMAX, DMAX, DMAX, DMAX, 0, 0, 1,
                {1'b1, 1'b0, 16'h00FF, 16'hFF00});
        add_row(OP_LOOKUP, 4, DMAX, DMAX, DMAX, 0, 0, 0, 1, MISS_NOT_FOUND);
        add_row(OP_INSERT, 7, 0, 0, 0, 0, 16'h5555, 16'hAAAA, 0, UNTYPED);
        add_row(OP_LOOKUP, 7, 0, 0, 0, 0, 0, 0, 0, UNTYPED);
        add_row(OP_INSERT, 1, 0, DMAX, DMAX, DMAX, 16'h8001, 16'h7FFE, 0, UNTYPED);
        add_row(OP_LOOKUP, 1, 0, 31'h2AAAAAAA, 31'h2AAAAAAA, 31'h2AAAAAAA, 0, 0, 0, UNTYPED);
        add_row(OP_INSERT, 3, 1, 2, 3, DMAX, 16'h0F0F, 16'hF0F0, 0, UNTYPED);
        add_row(OP_PEEK,   3, 1, 2, 3, 0, 0, 0, 0, UNTYPED);
        add_row(OP_PROBE,  3, 1, 2, 4, 0, 0, 0, 0, UNTYPED);
        add_row(OP_INSERT, 2, 31'h55555555, 31'h2AAAAAAA, 0, 0, 16'h7FFE, 16'h8001, 0, UNTYPED);
        add_row(OP_LOOKUP, 2, 31'h55555555, 31'h2AAAAAAA, 0, 0, 0, 0, 0, UNTYPED);
        add_row(OP_LOOKUP, 6, 0, 0, 0, 0, 0, 0, 0, UNTYPED);
        add_row(OP_INSERT, 4, DMAX, DMAX, DMAX, DMAX, 16'h0001, 16'h0002, 0, UNTYPED);
        add_row(OP_LOOKUP, 4, DMAX, DMAX, DMAX, DMAX, 0, 0, 0, UNTYPED);
        add_row(OP_PEEK,   0, 9, 9, 9, 9, 0, 0, 0, UNTYPED);

        // Hold reset
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Walk the directed rows at the reset capacity
        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            issue_request(row.req, sender_gap(32), row.typed, row.reply);
        end

        // Random phases, each with its own capacity and sender idling
        for (int p = 0; p < N_PHASES; p++) begin
            write_capacity(CAP_W'(cap_plan[p]));
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if ($urandom_range(0, 149) == 0) hold_until_drained();
                issue_request(random_request(), sender_gap(idle_plan[p]), 1'b0, UNTYPED);
            end
        end

        hold_until_drained();
        repeat (SETTLE_CYC) @(posedge i_clk);

        $display("Sent %0d requests, %0d replies (%0d hits), %0d capacity writes",
                 items_sent, reply_count, hit_count, cap_writes);
        $display("Capacity ran at 0, 1, 2, 4, 16, 17, 31 with sender idling at 0/32/57 pct");
        if (mismatch_count == 0 && awaited_replies.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
